// File: rtl/sn3d_pkg.sv
`default_nettype none
package sn3d_pkg;

	// Defaults for the top-level parameters
	localparam int OCTAVES_DEF    = 3;
	localparam int COORD_FRAC_DEF = 16;

	// Port widths
	localparam int COORD_W   = 24;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;

	// Datapath widths
	localparam int PW     = 42;      // scaled coordinate
	localparam int SW     = 44;      // skew sums and divide-by-3 operand
	localparam int IW     = SW - 16; // cell index
	localparam int DW     = 20;      // corner offset, Q.16
	localparam int SQW    = 24;      // squared offset, Q.16
	localparam int DOTW   = 21;      // gradient dot product
	localparam int CW     = 54;      // one corner contribution, Q.48
	localparam int SUMW   = 56;      // sum of four corners
	localparam int FREQ_W = 24;
	localparam int AMP_W  = 17;
	localparam int TW     = 48;      // one octave term, Q.32
	localparam int VW     = 32;      // value before saturation

	// Fixed-point constants, Q.16
	localparam int Q_ONE    = 65536;
	localparam int Q_G      = 10923;
	localparam int Q_2G     = 21845;
	localparam int Q_HALF   = 32768;
	localparam int Q_RADIUS = 39322;
	localparam int FREQ0    = 36045;
	localparam int FREQ_MUL = 153354;
	localparam int AMP_MUL  = 35389;

	typedef struct packed {
		logic       en;
		logic [7:0] xb;
	} sn3d_ctl_t;

	localparam logic [7:0] PERM_TAB [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96,
		8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142,
		8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247,
		8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203,
		8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56,
		8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165,
		8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83,
		8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
		8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63,
		8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226,
		8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82,
		8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182,
		8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2,
		8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172,
		8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113,
		8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228,
		8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
		8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49,
		8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204,
		8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236,
		8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128,
		8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	// Octave frequency in Q.16, grown by 2.34 per octave
	function automatic logic [FREQ_W-1:0] freq_at(input int o);
		longint f;
		f = FREQ0;
		for (int n = 0; n < o; n++)
			f = (f * FREQ_MUL + 32768) >>> 16;
		return f[FREQ_W-1:0];
	endfunction

	// Octave amplitude in Q.16, shrunk by 0.54 per octave
	function automatic logic [AMP_W-1:0] amp_at(input int o);
		longint a;
		a = Q_ONE;
		for (int n = 0; n < o; n++)
			a = (a * AMP_MUL + 32768) >>> 16;
		return a[AMP_W-1:0];
	endfunction

	// Floor division by 3: n = h*2^24 + l, and 2^24 - 1 is a multiple of 3
	function automatic logic signed [SW-1:0] div3(input logic signed [SW-1:0] n);
		logic signed [SW-25:0] h;
		logic [23:0]           l;
		logic signed [SW-1:0]  hp;
		logic [24:0]           u;
		logic [51:0]           up;
		logic signed [SW-1:0]  lo;
		h  = n[SW-1:24];
		l  = n[23:0];
		hp = h * 24'sd5592405;
		// bias the small remainder part positive, then reciprocal multiply
		u  = 25'(27'(h) + {3'b000, l} + 27'd3145728);
		up = u * 27'd89478486;
		lo = $signed({{(SW-24){1'b0}}, up[51:28]}) - SW'(1048576);
		return hp + lo;
	endfunction

	function automatic logic [3:0] mod12(input logic [7:0] p);
		logic [15:0] pq;
		logic [7:0]  q;
		pq = 16'(p) * 16'd171;
		q  = {3'b000, pq[15:11]};
		return 4'(p - 8'(q * 8'd12));
	endfunction

	function automatic logic [7:0] perm(input logic [7:0] idx, input logic [7:0] xb);
		return PERM_TAB[idx] ^ xb;
	endfunction

	// Dot of one of the twelve gradients (+-1,+-1,0 and its permutations) with an offset
	function automatic logic signed [DOTW-1:0] grad_dot(input logic [3:0] g,
			input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy,
			input logic signed [DW-1:0] dz);
		logic signed [DOTW-1:0] x;
		logic signed [DOTW-1:0] y;
		logic signed [DOTW-1:0] z;
		x = DOTW'(dx);
		y = DOTW'(dy);
		z = DOTW'(dz);
		unique case (g)
			4'd0:    return x + y;
			4'd1:    return y - x;
			4'd2:    return x - y;
			4'd3:    return -x - y;
			4'd4:    return x + z;
			4'd5:    return z - x;
			4'd6:    return x - z;
			4'd7:    return -x - z;
			4'd8:    return y + z;
			4'd9:    return z - y;
			4'd10:   return y - z;
			4'd11:   return -y - z;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [DW-1:0] offs(input logic signed [DW-1:0] v,
			input logic one, input logic signed [DW-1:0] bias);
		return v - (one ? DW'(Q_ONE) : DW'(0)) + bias;
	endfunction

endpackage
`default_nettype wire

// File: rtl/simplex_noise_3d_fractal_top.sv
`default_nettype none
// 3D simplex noise with fractal sum. Each beat on s_axis carries one point in
// signed fixed point (COORD_FRAC_BITS fraction bits); each beat on m_axis
// carries one Q2.14 noise value, saturated. fractal_mode 1 sums OCTAVES
// octaves, 0 gives one raw evaluation scaled by 32; seed scrambles the hash.
// The block takes one point every cycle while it is not stalled: OCTAVES evaluation
// lanes run side by side, each a 14-stage pipeline, followed by three stages that
// weight, sum and saturate. A two-entry output buffer keeps the pipeline moving
// after the sink stops; it stalls only when that buffer is full. Write configuration
// only while no point is in flight.
module simplex_noise_3d_fractal_top #(
	parameter int OCTAVES         = sn3d_pkg::OCTAVES_DEF,
	parameter int COORD_FRAC_BITS = sn3d_pkg::COORD_FRAC_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// coord_x [23:0], coord_y [47:24], coord_z [71:48]
	input  wire logic [3*sn3d_pkg::COORD_W-1:0]   s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// noise_value [15:0]
	output logic [sn3d_pkg::OUT_W-1:0]            m_axis_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [sn3d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sn3d_pkg::CFG_W-1:0]       cfg_data
);
	localparam int CWI   = sn3d_pkg::COORD_W;
	localparam int QW    = CWI + ((COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0);
	localparam int SUMW  = sn3d_pkg::SUMW;
	localparam int TW    = sn3d_pkg::TW;
	localparam int ACCW  = TW + 3;
	localparam int VW    = sn3d_pkg::VW;
	localparam int OUT_W = sn3d_pkg::OUT_W;
	localparam int LAT   = 17;

	logic [7:0]              xb_q;
	logic                    fractal_q;
	logic [LAT-1:0]          vld_q;
	sn3d_pkg::sn3d_ctl_t     ctl;
	logic signed [QW-1:0]    qx, qy, qz;
	logic signed [SUMW-1:0]  total [OCTAVES];
	logic signed [TW-1:0]    term_s15 [OCTAVES];
	logic signed [SUMW-30:0] raw_s15;
	logic signed [VW-1:0]    val_s16;
	logic [OUT_W-1:0]        res_s17;
	logic signed [ACCW-1:0]  acc_c;
	logic                    out_valid_q, skid_valid_q;
	logic [OUT_W-1:0]        out_data_q, skid_data_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xb_q      <= 8'd0;
			fractal_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sn3d_pkg::REG_SEED: xb_q <= cfg_data[7:0] ^ cfg_data[15:8]
					^ cfg_data[23:16] ^ cfg_data[31:24];
				sn3d_pkg::REG_MODE: fractal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance everywhere unless the output buffer holds a spare beat
	assign ctl.en        = !skid_valid_q;
	assign ctl.xb        = xb_q;
	assign s_axis_tready = ctl.en;

	// Bring coordinates to Q.16
	generate
		if (COORD_FRAC_BITS >= 16) begin : g_down
			assign qx = QW'($signed(s_axis_tdata[CWI-1:0]) >>> (COORD_FRAC_BITS - 16));
			assign qy = QW'($signed(s_axis_tdata[2*CWI-1:CWI]) >>> (COORD_FRAC_BITS - 16));
			assign qz = QW'($signed(s_axis_tdata[3*CWI-1:2*CWI]) >>> (COORD_FRAC_BITS - 16));
		end else begin : g_up
			assign qx = {s_axis_tdata[CWI-1:0], {(16 - COORD_FRAC_BITS){1'b0}}};
			assign qy = {s_axis_tdata[2*CWI-1:CWI], {(16 - COORD_FRAC_BITS){1'b0}}};
			assign qz = {s_axis_tdata[3*CWI-1:2*CWI], {(16 - COORD_FRAC_BITS){1'b0}}};
		end
	endgenerate

	// One evaluation lane per octave; the first runs at unit frequency in raw mode
	generate
		for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
			logic [sn3d_pkg::FREQ_W-1:0] freq;
			if (o == 0) begin : g_first
				assign freq = fractal_q ? sn3d_pkg::freq_at(0)
					: sn3d_pkg::FREQ_W'(sn3d_pkg::Q_ONE);
			end else begin : g_rest
				assign freq = sn3d_pkg::freq_at(o);
			end
			sn3d_lane #(.QW(QW)) u_lane (
				.clk   (clk),
				.ctl   (ctl),
				.freq  (freq),
				.cx    (qx),
				.cy    (qy),
				.cz    (qz),
				.total (total[o])
			);
		end
	endgenerate

	// Track beats through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (ctl.en)
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	always_comb begin
		acc_c = '0;
		for (int o = 0; o < OCTAVES; o++)
			acc_c = acc_c + ACCW'(term_s15[o]);
	end

	// Weight each octave and sum, or take the first lane's raw value, then saturate
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int o = 0; o < OCTAVES; o++)
				term_s15[o] <= TW'((SUMW-26)'(total[o] >>> 27)
					+ (SUMW-26)'(sn3d_pkg::Q_ONE))
					* TW'($signed({1'b0, sn3d_pkg::amp_at(o)}));
			raw_s15 <= (SUMW-29)'(total[0] >>> 29);
			val_s16 <= fractal_q ? VW'(acc_c >>> 19) : VW'(raw_s15);
			if (val_s16 > VW'(32767))
				res_s17 <= OUT_W'(32767);
			else if (val_s16 < -VW'(32768))
				res_s17 <= OUT_W'(-32768);
			else
				res_s17 <= val_s16[OUT_W-1:0];
		end
	end

	// Output register with one spare entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (ctl.en) begin
			if (!out_valid_q || m_axis_tready)
				out_valid_q <= vld_q[LAT-1];
			else if (vld_q[LAT-1])
				skid_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (!out_valid_q || m_axis_tready)
				out_data_q <= res_s17;
			else
				skid_data_q <= res_s17;
		end else if (m_axis_tready) begin
			out_data_q <= skid_data_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

// File: rtl/sn3d_lane.sv
`default_nettype none
// One simplex evaluation, fourteen register stages from scaled point to corner sum
module sn3d_lane #(
	parameter int QW = sn3d_pkg::COORD_W
) (
	input  wire logic                                  clk,
	input  wire sn3d_pkg::sn3d_ctl_t                   ctl,
	input  wire logic [sn3d_pkg::FREQ_W-1:0]           freq,
	input  wire logic signed [QW-1:0]                  cx,
	input  wire logic signed [QW-1:0]                  cy,
	input  wire logic signed [QW-1:0]                  cz,
	output logic signed [sn3d_pkg::SUMW-1:0]           total
);
	localparam int PW   = sn3d_pkg::PW;
	localparam int SW   = sn3d_pkg::SW;
	localparam int IW   = sn3d_pkg::IW;
	localparam int DW   = sn3d_pkg::DW;
	localparam int SQW  = sn3d_pkg::SQW;
	localparam int DOTW = sn3d_pkg::DOTW;
	localparam int CW   = sn3d_pkg::CW;
	localparam int SUMW = sn3d_pkg::SUMW;
	localparam int FW   = sn3d_pkg::FREQ_W;

	logic signed [PW-1:0]   x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic signed [PW-1:0]   x_s4, y_s4, z_s4, x_s5, y_s5, z_s5, x_s6, y_s6, z_s6;
	logic signed [SW-1:0]   sum_s2, s_s3, tq_s5, t_s6;
	logic signed [IW-1:0]   i_s4, j_s4, k_s4, i_s5, j_s5, k_s5, i_s6, j_s6, k_s6;
	logic [1:0]             m_s5;
	logic [7:0]             pk_s5 [2];
	logic [7:0]             pj_s6 [4];
	logic [3:0]             g_s7 [8];
	logic signed [DW-1:0]   x0_s7, y0_s7, z0_s7;
	logic signed [DW-1:0]   d_s8 [4][3];
	logic [3:0]             gc_s8 [4];
	logic [SQW-1:0]         sq_s9 [4][3];
	logic signed [DOTW-1:0] dot_s9 [4], dot_s10 [4], dot_s11 [4], dot_s12 [4];
	logic [15:0]            rp_s10 [4], r2_s11 [4];
	logic [31:0]            r4_s12 [4];
	logic signed [CW-1:0]   c_s13 [4];

	logic signed [QW+FW:0]  px, py, pz;
	logic signed [IW+1:0]   m_c;
	logic [1:0]             rem_c;
	logic [2:0]             o1_c, o2_c;
	logic signed [2*DW-1:0] sqp_c [4][3];
	logic signed [SQW+2:0]  r_c [4];

	// Scale the point by the octave frequency
	always_comb begin
		px = cx * $signed({1'b0, freq});
		py = cy * $signed({1'b0, freq});
		pz = cz * $signed({1'b0, freq});
	end

	// Index sum and its remainder, the simplex traversal order, and the squares and falloff terms
	always_comb begin
		m_c   = IW'(0) + (IW+2)'(i_s4) + (IW+2)'(j_s4) + (IW+2)'(k_s4);
		rem_c = 2'(m_s5 - 2'(tq_s5[1:0] * 2'd3));
		if (x0_s7 >= y0_s7) begin
			if (y0_s7 >= z0_s7) begin
				o1_c = 3'b100; o2_c = 3'b110;
			end else if (x0_s7 >= z0_s7) begin
				o1_c = 3'b100; o2_c = 3'b101;
			end else begin
				o1_c = 3'b001; o2_c = 3'b101;
			end
		end else begin
			if (y0_s7 < z0_s7) begin
				o1_c = 3'b001; o2_c = 3'b011;
			end else if (x0_s7 < z0_s7) begin
				o1_c = 3'b010; o2_c = 3'b011;
			end else begin
				o1_c = 3'b010; o2_c = 3'b110;
			end
		end
		for (int n = 0; n < 4; n++) begin
			for (int a = 0; a < 3; a++)
				sqp_c[n][a] = d_s8[n][a] * d_s8[n][a];
			r_c[n] = (SQW+3)'(sn3d_pkg::Q_RADIUS) - (SQW+3)'(sq_s9[n][0])
				- (SQW+3)'(sq_s9[n][1]) - (SQW+3)'(sq_s9[n][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// scaled point
			x_s1 <= PW'(px >>> 16);
			y_s1 <= PW'(py >>> 16);
			z_s1 <= PW'(pz >>> 16);
			// skew sum
			sum_s2 <= SW'(x_s1) + SW'(y_s1) + SW'(z_s1);
			x_s2 <= x_s1; y_s2 <= y_s1; z_s2 <= z_s1;
			s_s3 <= sn3d_pkg::div3(sum_s2);
			x_s3 <= x_s2; y_s3 <= y_s2; z_s3 <= z_s2;
			// cell index
			i_s4 <= IW'((SW'(x_s3) + s_s3) >>> 16);
			j_s4 <= IW'((SW'(y_s3) + s_s3) >>> 16);
			k_s4 <= IW'((SW'(z_s3) + s_s3) >>> 16);
			x_s4 <= x_s3; y_s4 <= y_s3; z_s4 <= z_s3;
			// unskew quotient and first hash level
			tq_s5 <= sn3d_pkg::div3(SW'(m_c));
			m_s5  <= m_c[1:0];
			for (int c = 0; c < 2; c++)
				pk_s5[c] <= sn3d_pkg::perm(8'(k_s4[7:0] + 8'(c)), ctl.xb);
			i_s5 <= i_s4; j_s5 <= j_s4; k_s5 <= k_s4;
			x_s5 <= x_s4; y_s5 <= y_s4; z_s5 <= z_s4;
			// unskew offset and second hash level
			unique case (rem_c)
				2'd1:    t_s6 <= (tq_s5 <<< 15) + SW'(10922);
				2'd2:    t_s6 <= (tq_s5 <<< 15) + SW'(21845);
				default: t_s6 <= tq_s5 <<< 15;
			endcase
			for (int bc = 0; bc < 4; bc++)
				pj_s6[bc] <= sn3d_pkg::perm(8'(j_s5[7:0] + 8'(bc >> 1) + pk_s5[bc & 1]),
					ctl.xb);
			i_s6 <= i_s5; j_s6 <= j_s5; k_s6 <= k_s5;
			x_s6 <= x_s5; y_s6 <= y_s5; z_s6 <= z_s5;
			// first corner offset and gradient indexes
			x0_s7 <= DW'(SW'(x_s6) - (SW'(i_s6) <<< 16) + t_s6);
			y0_s7 <= DW'(SW'(y_s6) - (SW'(j_s6) <<< 16) + t_s6);
			z0_s7 <= DW'(SW'(z_s6) - (SW'(k_s6) <<< 16) + t_s6);
			for (int abc = 0; abc < 8; abc++)
				g_s7[abc] <= sn3d_pkg::mod12(sn3d_pkg::perm(
					8'(i_s6[7:0] + 8'(abc >> 2) + pj_s6[abc & 3]), ctl.xb));
			// four corner offsets and their gradients
			d_s8[0][0] <= x0_s7; d_s8[0][1] <= y0_s7; d_s8[0][2] <= z0_s7;
			d_s8[1][0] <= sn3d_pkg::offs(x0_s7, o1_c[2], DW'(sn3d_pkg::Q_G));
			d_s8[1][1] <= sn3d_pkg::offs(y0_s7, o1_c[1], DW'(sn3d_pkg::Q_G));
			d_s8[1][2] <= sn3d_pkg::offs(z0_s7, o1_c[0], DW'(sn3d_pkg::Q_G));
			d_s8[2][0] <= sn3d_pkg::offs(x0_s7, o2_c[2], DW'(sn3d_pkg::Q_2G));
			d_s8[2][1] <= sn3d_pkg::offs(y0_s7, o2_c[1], DW'(sn3d_pkg::Q_2G));
			d_s8[2][2] <= sn3d_pkg::offs(z0_s7, o2_c[0], DW'(sn3d_pkg::Q_2G));
			d_s8[3][0] <= sn3d_pkg::offs(x0_s7, 1'b0, -DW'(sn3d_pkg::Q_HALF));
			d_s8[3][1] <= sn3d_pkg::offs(y0_s7, 1'b0, -DW'(sn3d_pkg::Q_HALF));
			d_s8[3][2] <= sn3d_pkg::offs(z0_s7, 1'b0, -DW'(sn3d_pkg::Q_HALF));
			gc_s8[0] <= g_s7[0];
			gc_s8[1] <= g_s7[o1_c];
			gc_s8[2] <= g_s7[o2_c];
			gc_s8[3] <= g_s7[7];
			for (int n = 0; n < 4; n++) begin
				// squares and dot products
				for (int a = 0; a < 3; a++)
					sq_s9[n][a] <= sqp_c[n][a][2*DW-1:16];
				dot_s9[n] <= sn3d_pkg::grad_dot(gc_s8[n], d_s8[n][0], d_s8[n][1],
					d_s8[n][2]);
				// falloff, zero outside the radius
				rp_s10[n]  <= (r_c[n] > 0) ? r_c[n][15:0] : 16'd0;
				dot_s10[n] <= dot_s9[n];
				r2_s11[n]  <= 16'((32'(rp_s10[n]) * 32'(rp_s10[n])) >> 16);
				dot_s11[n] <= dot_s10[n];
				r4_s12[n]  <= 32'(r2_s11[n]) * 32'(r2_s11[n]);
				dot_s12[n] <= dot_s11[n];
				c_s13[n]   <= CW'($signed({1'b0, r4_s12[n]})) * CW'(dot_s12[n]);
			end
			total <= SUMW'(c_s13[0]) + SUMW'(c_s13[1]) + SUMW'(c_s13[2])
				+ SUMW'(c_s13[3]);
		end
	end
endmodule
`default_nettype wire
